@@ hw/rtl/ccr_pkg.sv @@
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types and constants of the circumcircle center and radius pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package ccr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int OUT_W    = 48;
  localparam int DIFF_EXP = 49;
  localparam int SQ_BITS  = 50;
  localparam int SQ_S_W   = 2 * SQ_BITS;
  localparam int SQ_R_W   = SQ_BITS + 2;
  localparam int SQ_LO    = 25;

  localparam logic signed [OUT_W-1:0] CTR_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [OUT_W-1:0] CTR_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic vld;
    logic gnz;
    logic negx;
    logic negy;
    logic sat;
    logic big;
  } ccr_ctl_t;

  typedef struct packed {
    logic                    has_circle;
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic [OUT_W-1:0]        radius;
    logic                    saturated;
  } ccr_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/ccr_if.sv @@
// ----------------------------------------------------------------------------
// ccr_if
// Item channels of the circumcircle pipeline: triangle in, circle out.
// ----------------------------------------------------------------------------
`default_nettype none
interface ccr_in_if #(parameter int CW = ccr_pkg::COORD_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] first_x;
  logic signed [CW-1:0] first_y;
  logic signed [CW-1:0] second_x;
  logic signed [CW-1:0] second_y;
  logic signed [CW-1:0] third_x;
  logic signed [CW-1:0] third_y;

  modport source (output valid, first_x, first_y, second_x, second_y, third_x, third_y,
                  input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, third_x, third_y,
                output ready);
endinterface

interface ccr_out_if;
  logic                                valid;
  logic                                ready;
  logic                                has_circle;
  logic signed [ccr_pkg::OUT_W-1:0]    center_x;
  logic signed [ccr_pkg::OUT_W-1:0]    center_y;
  logic [ccr_pkg::OUT_W-1:0]           radius;
  logic                                saturated;

  modport source (output valid, has_circle, center_x, center_y, radius, saturated,
                  input ready);
  modport sink (input valid, has_circle, center_x, center_y, radius, saturated,
                output ready);
endinterface
`default_nettype wire

@@ hw/rtl/circumcircle_center_radius.sv @@
// ----------------------------------------------------------------------------
// circumcircle_center_radius
// Center and radius of the circle through three integer points, fixed point.
// ----------------------------------------------------------------------------
// One divider cell per quotient bit and one root cell per root bit.
// Throughput: one item per cycle; a full output plus skid stage holds input.
// Reset: synchronous active low, clears all valid bits; data is not reset.
`default_nettype none
module circumcircle_center_radius #(
  parameter int COORD_BITS = ccr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ccr_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ccr_in_if.sink    in_ch,
  ccr_out_if.source out_ch
);
  import ccr_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DW1  = C + 1;
  localparam int PW   = 2 * C + 2;
  localparam int EW   = 2 * C + 3;
  localparam int GW   = 2 * C + 4;
  localparam int K    = C + 1;
  localparam int PPW  = 2 * C + 3;
  localparam int MW   = 3 * C + 4;
  localparam int NW   = MW + 1;
  localparam int DVW  = NW + F;
  localparam int QW   = DVW + 1;
  localparam int CMW  = (QW > DIFF_EXP) ? QW : DIFF_EXP;
  localparam int DXW  = CMW + 1;
  localparam int SDW  = 2 * C;
  localparam int CCW  = 2 * OUT_W;

  logic en;
  logic take;
  logic out_v_r, skid_v_r;
  ccr_res_t out_r, skid_r, res_nxt;

  assign en = !skid_v_r;
  assign take = out_ch.ready || !out_v_r;
  assign in_ch.ready = en;

  // front end
  logic [6:0] v_r;
  logic signed [C-1:0] x1_sh_r [0:6];
  logic signed [C-1:0] y1_sh_r [0:6];
  logic signed [C-1:0] x2_r, y2_r, x3_r, y3_r;

  logic signed [C:0] a1_r, b1_r, c1_r, d1_r, sx12_r, sy12_r, sx13_r, sy13_r, dy32_r, dx32_r;
  logic signed [C:0] a2_r, b2_r, c2_r, d2_r, a3_r, b3_r, c3_r, d3_r;
  logic signed [PW-1:0] m1_r, m2_r, m3_r, m4_r, m5_r, m6_r;
  logic signed [EW-1:0] e3_r, f3_r;
  logic signed [GW-1:0] g3_r, g4_r, g5_r, g6_r;
  logic signed [PPW-1:0] edl_r, edh_r, fbl_r, fbh_r, fal_r, fah_r, ecl_r, ech_r;
  logic signed [MW-1:0] ed_r, fb_r, fa_r, ec_r;
  logic signed [NW-1:0] nx_r, ny_r;

  ccr_ctl_t ctl7_r;
  logic [NW-1:0] nxa_r, nya_r;
  logic [GW-1:0] ga_r;
  logic signed [C-1:0] x1_7_r, y1_7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      ctl7_r <= '0;
    end else if (en) begin
      v_r         <= {v_r[5:0], in_ch.valid};
      ctl7_r.vld  <= v_r[6];
      ctl7_r.gnz  <= g6_r != '0;
      ctl7_r.negx <= nx_r[NW-1] ^ g6_r[GW-1];
      ctl7_r.negy <= ny_r[NW-1] ^ g6_r[GW-1];
      ctl7_r.sat  <= 1'b0;
      ctl7_r.big  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_sh_r[0] <= in_ch.first_x[C-1:0];
      y1_sh_r[0] <= in_ch.first_y[C-1:0];
      x2_r <= in_ch.second_x[C-1:0];
      y2_r <= in_ch.second_y[C-1:0];
      x3_r <= in_ch.third_x[C-1:0];
      y3_r <= in_ch.third_y[C-1:0];
      for (int k = 1; k < 7; k++) begin
        x1_sh_r[k] <= x1_sh_r[k-1];
        y1_sh_r[k] <= y1_sh_r[k-1];
      end
      // differences and sums
      a1_r   <= DW1'(x2_r) - DW1'(x1_sh_r[0]);
      b1_r   <= DW1'(y2_r) - DW1'(y1_sh_r[0]);
      c1_r   <= DW1'(x3_r) - DW1'(x1_sh_r[0]);
      d1_r   <= DW1'(y3_r) - DW1'(y1_sh_r[0]);
      sx12_r <= DW1'(x2_r) + DW1'(x1_sh_r[0]);
      sy12_r <= DW1'(y2_r) + DW1'(y1_sh_r[0]);
      sx13_r <= DW1'(x3_r) + DW1'(x1_sh_r[0]);
      sy13_r <= DW1'(y3_r) + DW1'(y1_sh_r[0]);
      dy32_r <= DW1'(y3_r) - DW1'(y2_r);
      dx32_r <= DW1'(x3_r) - DW1'(x2_r);
      // first products
      m1_r <= PW'(a1_r) * PW'(sx12_r);
      m2_r <= PW'(b1_r) * PW'(sy12_r);
      m3_r <= PW'(c1_r) * PW'(sx13_r);
      m4_r <= PW'(d1_r) * PW'(sy13_r);
      m5_r <= PW'(a1_r) * PW'(dy32_r);
      m6_r <= PW'(b1_r) * PW'(dx32_r);
      a2_r <= a1_r; b2_r <= b1_r; c2_r <= c1_r; d2_r <= d1_r;
      // e, f, g
      e3_r <= EW'(m1_r) + EW'(m2_r);
      f3_r <= EW'(m3_r) + EW'(m4_r);
      g3_r <= (GW'(m5_r) - GW'(m6_r)) <<< 1;
      a3_r <= a2_r; b3_r <= b2_r; c3_r <= c2_r; d3_r <= d2_r;
      // split products, low half unsigned
      edl_r <= PPW'($signed({1'b0, e3_r[K-1:0]})) * PPW'(d3_r);
      edh_r <= PPW'($signed(e3_r[EW-1:K])) * PPW'(d3_r);
      fbl_r <= PPW'($signed({1'b0, f3_r[K-1:0]})) * PPW'(b3_r);
      fbh_r <= PPW'($signed(f3_r[EW-1:K])) * PPW'(b3_r);
      fal_r <= PPW'($signed({1'b0, f3_r[K-1:0]})) * PPW'(a3_r);
      fah_r <= PPW'($signed(f3_r[EW-1:K])) * PPW'(a3_r);
      ecl_r <= PPW'($signed({1'b0, e3_r[K-1:0]})) * PPW'(c3_r);
      ech_r <= PPW'($signed(e3_r[EW-1:K])) * PPW'(c3_r);
      g4_r  <= g3_r;
      ed_r  <= (MW'(edh_r) <<< K) + MW'(edl_r);
      fb_r  <= (MW'(fbh_r) <<< K) + MW'(fbl_r);
      fa_r  <= (MW'(fah_r) <<< K) + MW'(fal_r);
      ec_r  <= (MW'(ech_r) <<< K) + MW'(ecl_r);
      g5_r  <= g4_r;
      nx_r  <= NW'(ed_r) - NW'(fb_r);
      ny_r  <= NW'(fa_r) - NW'(ec_r);
      g6_r  <= g5_r;
      // magnitudes for the divider
      nxa_r  <= nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
      nya_r  <= ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
      ga_r   <= g6_r[GW-1] ? GW'(-g6_r) : GW'(g6_r);
      x1_7_r <= x1_sh_r[6];
      y1_7_r <= y1_sh_r[6];
    end
  end

  // divider chain
  ccr_ctl_t dctl_w [0:DVW];
  logic [GW-1:0]  dvs_w  [0:DVW];
  logic [GW-1:0]  remx_w [0:DVW];
  logic [GW-1:0]  remy_w [0:DVW];
  logic [DVW-1:0] dqx_w  [0:DVW];
  logic [DVW-1:0] dqy_w  [0:DVW];
  logic [SDW-1:0] dsd_w  [0:DVW];

  assign dctl_w[0] = ctl7_r;
  assign dvs_w[0]  = ga_r;
  assign remx_w[0] = '0;
  assign remy_w[0] = '0;
  assign dqx_w[0]  = DVW'(nxa_r) << F;
  assign dqy_w[0]  = DVW'(nya_r) << F;
  assign dsd_w[0]  = {x1_7_r, y1_7_r};

  for (genvar i = 0; i < DVW; i++) begin : g_div
    ccr_div_cell #(.GW(GW), .DW(DVW), .SW(SDW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_i(dctl_w[i]), .div_i(dvs_w[i]),
      .remx_i(remx_w[i]), .dqx_i(dqx_w[i]), .remy_i(remy_w[i]), .dqy_i(dqy_w[i]),
      .side_i(dsd_w[i]),
      .ctl_o(dctl_w[i+1]), .div_o(dvs_w[i+1]),
      .remx_o(remx_w[i+1]), .dqx_o(dqx_w[i+1]), .remy_o(remy_w[i+1]), .dqy_o(dqy_w[i+1]),
      .side_o(dsd_w[i+1])
    );
  end

  function automatic logic signed [QW-1:0] c8_nx(input logic neg, input logic [DVW-1:0] q);
    logic signed [QW-1:0] m;
    m = $signed({1'b0, q});
    return neg ? -m : m;
  endfunction

  // center, clip, distance
  ccr_ctl_t c8_r, c9_r, c10_r, c11_r, c12_r, c13_r;
  ccr_ctl_t c9_nxt, c10_nxt;
  logic signed [QW-1:0] cx8_r, cy8_r;
  logic signed [C-1:0] x1_8_r, y1_8_r;
  logic signed [CMW-1:0] cxe, cye;
  logic signed [OUT_W-1:0] ccx_nxt, ccy_nxt;
  logic satx, saty;
  logic [CCW-1:0] cc_sh_r [0:4];
  logic signed [DXW-1:0] dx9_r, dy9_r;
  logic [DXW-1:0] adx, ady;
  logic [DIFF_EXP-1:0] adx10_r, ady10_r;
  logic [47:0] hhx_r, hhy_r;
  logic [48:0] hlx_r, hly_r;
  logic [49:0] llx_r, lly_r;
  logic [SQ_S_W-1:0] sqx_r, sqy_r, s13_r;

  always_comb begin
    cxe = CMW'(cx8_r);
    cye = CMW'(cy8_r);
    satx = 1'b0;
    saty = 1'b0;
    ccx_nxt = cxe[OUT_W-1:0];
    ccy_nxt = cye[OUT_W-1:0];
    if (cxe > CMW'(CTR_MAX)) begin
      ccx_nxt = CTR_MAX;
      satx = 1'b1;
    end else if (cxe < CMW'(CTR_MIN)) begin
      ccx_nxt = CTR_MIN;
      satx = 1'b1;
    end
    if (cye > CMW'(CTR_MAX)) begin
      ccy_nxt = CTR_MAX;
      saty = 1'b1;
    end else if (cye < CMW'(CTR_MIN)) begin
      ccy_nxt = CTR_MIN;
      saty = 1'b1;
    end
  end

  assign adx = dx9_r[DXW-1] ? DXW'(-dx9_r) : DXW'(dx9_r);
  assign ady = dy9_r[DXW-1] ? DXW'(-dy9_r) : DXW'(dy9_r);

  always_comb begin
    c9_nxt      = c8_r;
    c9_nxt.sat  = satx || saty;
    c10_nxt     = c9_r;
    c10_nxt.big = (adx[DXW-1:DIFF_EXP] != '0) || (ady[DXW-1:DIFF_EXP] != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c8_r <= '0; c9_r <= '0; c10_r <= '0; c11_r <= '0; c12_r <= '0; c13_r <= '0;
    end else if (en) begin
      c8_r  <= dctl_w[DVW];
      c9_r  <= c9_nxt;
      c10_r <= c10_nxt;
      c11_r <= c10_r;
      c12_r <= c11_r;
      c13_r <= c12_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx8_r  <= c8_nx(dctl_w[DVW].negx, dqx_w[DVW]);
      cy8_r  <= c8_nx(dctl_w[DVW].negy, dqy_w[DVW]);
      x1_8_r <= dsd_w[DVW][SDW-1:C];
      y1_8_r <= dsd_w[DVW][C-1:0];
      cc_sh_r[0] <= {ccx_nxt, ccy_nxt};
      for (int k = 1; k < 5; k++) begin
        cc_sh_r[k] <= cc_sh_r[k-1];
      end
      dx9_r <= DXW'(cx8_r) - (DXW'(x1_8_r) <<< F);
      dy9_r <= DXW'(cy8_r) - (DXW'(y1_8_r) <<< F);
      adx10_r <= adx[DIFF_EXP-1:0];
      ady10_r <= ady[DIFF_EXP-1:0];
      hhx_r <= 48'(adx10_r[DIFF_EXP-1:SQ_LO]) * 48'(adx10_r[DIFF_EXP-1:SQ_LO]);
      hlx_r <= 49'(adx10_r[DIFF_EXP-1:SQ_LO]) * 49'(adx10_r[SQ_LO-1:0]);
      llx_r <= 50'(adx10_r[SQ_LO-1:0]) * 50'(adx10_r[SQ_LO-1:0]);
      hhy_r <= 48'(ady10_r[DIFF_EXP-1:SQ_LO]) * 48'(ady10_r[DIFF_EXP-1:SQ_LO]);
      hly_r <= 49'(ady10_r[DIFF_EXP-1:SQ_LO]) * 49'(ady10_r[SQ_LO-1:0]);
      lly_r <= 50'(ady10_r[SQ_LO-1:0]) * 50'(ady10_r[SQ_LO-1:0]);
      sqx_r <= (SQ_S_W'(hhx_r) << (2 * SQ_LO)) + (SQ_S_W'(hlx_r) << (SQ_LO + 1))
               + SQ_S_W'(llx_r);
      sqy_r <= (SQ_S_W'(hhy_r) << (2 * SQ_LO)) + (SQ_S_W'(hly_r) << (SQ_LO + 1))
               + SQ_S_W'(lly_r);
      s13_r <= sqx_r + sqy_r;
    end
  end

  // square root chain
  ccr_ctl_t sctl_w [0:SQ_BITS];
  logic [SQ_R_W-1:0]  srem_w  [0:SQ_BITS];
  logic [SQ_BITS-1:0] sroot_w [0:SQ_BITS];
  logic [SQ_S_W-1:0]  srad_w  [0:SQ_BITS];
  logic [CCW-1:0]     ssd_w   [0:SQ_BITS];

  assign sctl_w[0]  = c13_r;
  assign srem_w[0]  = '0;
  assign sroot_w[0] = '0;
  assign srad_w[0]  = s13_r;
  assign ssd_w[0]   = cc_sh_r[4];

  for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
    ccr_sqrt_cell #(.SW(CCW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_i(sctl_w[j]), .rem_i(srem_w[j]), .root_i(sroot_w[j]), .rad_i(srad_w[j]),
      .side_i(ssd_w[j]),
      .ctl_o(sctl_w[j+1]), .rem_o(srem_w[j+1]), .root_o(sroot_w[j+1]),
      .rad_o(srad_w[j+1]), .side_o(ssd_w[j+1])
    );
  end

  logic rsat;
  assign rsat = sctl_w[SQ_BITS].big || (sroot_w[SQ_BITS][SQ_BITS-1:OUT_W] != '0);

  always_comb begin
    res_nxt.has_circle = 1'b1;
    res_nxt.center_x   = ssd_w[SQ_BITS][CCW-1:OUT_W];
    res_nxt.center_y   = ssd_w[SQ_BITS][OUT_W-1:0];
    res_nxt.radius     = rsat ? '1 : sroot_w[SQ_BITS][OUT_W-1:0];
    res_nxt.saturated  = sctl_w[SQ_BITS].sat || rsat;
    if (!sctl_w[SQ_BITS].gnz) begin
      res_nxt = '0;
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= sctl_w[SQ_BITS].vld;
      end
    end else if (en && sctl_w[SQ_BITS].vld) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= skid_v_r ? skid_r : res_nxt;
    end else if (en) begin
      skid_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.has_circle = out_r.has_circle;
  assign out_ch.center_x   = out_r.center_x;
  assign out_ch.center_y   = out_r.center_y;
  assign out_ch.radius     = out_r.radius;
  assign out_ch.saturated  = out_r.saturated;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid holds an item while output is empty");

  a_no_circle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.has_circle) |->
      (out_r.center_x == '0 && out_r.center_y == '0 && out_r.radius == '0
       && !out_r.saturated)) else $error("collinear item carries nonzero fields");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_ch.ready) |=> (out_v_r && !skid_v_r))
    else $error("skid item not moved to output");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/ccr_div_cell.sv @@
// ----------------------------------------------------------------------------
// ccr_div_cell
// One restoring division step for both center coordinates, shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module ccr_div_cell #(
  parameter int GW = 8,
  parameter int DW = 8,
  parameter int SW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ccr_pkg::ccr_ctl_t ctl_i,
  input  logic [GW-1:0]     div_i,
  input  logic [GW-1:0]     remx_i,
  input  logic [DW-1:0]     dqx_i,
  input  logic [GW-1:0]     remy_i,
  input  logic [DW-1:0]     dqy_i,
  input  logic [SW-1:0]     side_i,
  output ccr_pkg::ccr_ctl_t ctl_o,
  output logic [GW-1:0]     div_o,
  output logic [GW-1:0]     remx_o,
  output logic [DW-1:0]     dqx_o,
  output logic [GW-1:0]     remy_o,
  output logic [DW-1:0]     dqy_o,
  output logic [SW-1:0]     side_o
);
  import ccr_pkg::*;

  logic [GW:0]   tx, ty, dv;
  logic          gex, gey;
  logic [GW-1:0] remx_nxt, remy_nxt;
  logic [DW-1:0] dqx_nxt, dqy_nxt;

  ccr_ctl_t      ctl_r;
  logic [GW-1:0] div_r, remx_r, remy_r;
  logic [DW-1:0] dqx_r, dqy_r;
  logic [SW-1:0] side_r;

  assign dv  = {1'b0, div_i};
  assign tx  = {remx_i, dqx_i[DW-1]};
  assign ty  = {remy_i, dqy_i[DW-1]};
  assign gex = tx >= dv;
  assign gey = ty >= dv;
  assign remx_nxt = gex ? GW'(tx - dv) : tx[GW-1:0];
  assign remy_nxt = gey ? GW'(ty - dv) : ty[GW-1:0];
  assign dqx_nxt  = {dqx_i[DW-2:0], gex};
  assign dqy_nxt  = {dqy_i[DW-2:0], gey};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r  <= div_i;
      remx_r <= remx_nxt;
      remy_r <= remy_nxt;
      dqx_r  <= dqx_nxt;
      dqy_r  <= dqy_nxt;
      side_r <= side_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign div_o  = div_r;
  assign remx_o = remx_r;
  assign remy_o = remy_r;
  assign dqx_o  = dqx_r;
  assign dqy_o  = dqy_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

@@ hw/rtl/ccr_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// ccr_sqrt_cell
// One digit step of the integer square root, two radicand bits per cell.
// ----------------------------------------------------------------------------
`default_nettype none
module ccr_sqrt_cell #(
  parameter int SW = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  ccr_pkg::ccr_ctl_t            ctl_i,
  input  logic [ccr_pkg::SQ_R_W-1:0]   rem_i,
  input  logic [ccr_pkg::SQ_BITS-1:0]  root_i,
  input  logic [ccr_pkg::SQ_S_W-1:0]   rad_i,
  input  logic [SW-1:0]                side_i,
  output ccr_pkg::ccr_ctl_t            ctl_o,
  output logic [ccr_pkg::SQ_R_W-1:0]   rem_o,
  output logic [ccr_pkg::SQ_BITS-1:0]  root_o,
  output logic [ccr_pkg::SQ_S_W-1:0]   rad_o,
  output logic [SW-1:0]                side_o
);
  import ccr_pkg::*;

  logic [SQ_R_W+1:0]  t, trial;
  logic               ge;
  ccr_ctl_t           ctl_r;
  logic [SQ_R_W-1:0]  rem_r;
  logic [SQ_BITS-1:0] root_r;
  logic [SQ_S_W-1:0]  rad_r;
  logic [SW-1:0]      side_r;

  assign t     = {rem_i, rad_i[SQ_S_W-1 -: 2]};
  assign trial = (SQ_R_W + 2)'({root_i, 2'b01});
  assign ge    = t >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? SQ_R_W'(t - trial) : SQ_R_W'(t);
      root_r <= {root_i[SQ_BITS-2:0], ge};
      rad_r  <= {rad_i[SQ_S_W-3:0], 2'b00};
      side_r <= side_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;
  assign side_o = side_r;
endmodule
`default_nettype wire
